@@ rtl/kmeans_centroid_merge_update_defines.svh @@
// ----------------------------------------------------------------------------
// kmeans_centroid_merge_update_defines
// assertion macros shared by the centroid merge and update block
// ----------------------------------------------------------------------------
`ifndef KMEANS_CENTROID_MERGE_UPDATE_DEFINES_SVH
`define KMEANS_CENTROID_MERGE_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define KCMU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kcmu assertion failed");

// condition must never be seen outside reset
`define KCMU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("kcmu forbidden condition seen");

`else

`define KCMU_ASSERT(lbl, clk, rst_n, prop)
`define KCMU_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/kcmu_pkg.sv @@
// ----------------------------------------------------------------------------
// kcmu_pkg
// constants and types of the k-means centroid merge and update block
// ----------------------------------------------------------------------------
package kcmu_pkg;

    localparam int LANES         = 16;
    localparam int MAX_CLUSTERS  = 256;
    localparam int LANE_W        = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CLUSTER_LIMIT = (MAX_CLUSTERS < 256) ? MAX_CLUSTERS : 256;

    localparam int CC_W     = 9;
    localparam int IDX_W    = 8;
    localparam int COORD_W  = 32;
    localparam int SUM_W    = 48;
    localparam int PTS_IN_W = 25;
    localparam int PT_W     = 29;
    localparam int ACC_W    = 54;
    localparam int TOT_W    = PT_W + 1;
    localparam int REM_W    = PT_W + 1;

    localparam int DIV_STEPS = ACC_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0]  old_x;
        logic signed [COORD_W-1:0]  old_y;
        logic        [PTS_IN_W-1:0] lane_points;
        logic signed [SUM_W-1:0]    lane_sum_x;
        logic signed [SUM_W-1:0]    lane_sum_y;
    } t_in_item;

    typedef struct packed {
        logic        [IDX_W-1:0]   cluster_index;
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic                      empty_cluster;
        logic                      last_cluster;
    } t_out_item;

    // one merged cluster, waiting for division
    typedef struct packed {
        logic        [IDX_W-1:0] cluster_index;
        logic signed [ACC_W-1:0] numer_x;
        logic signed [ACC_W-1:0] numer_y;
        logic        [PT_W-1:0]  points;
        logic                    last_cluster;
    } t_rec;

endpackage

@@ rtl/kcmu_front.sv @@
// ----------------------------------------------------------------------------
// kcmu_front
// merges lane records of one cluster and hands the totals to the queue
// ----------------------------------------------------------------------------
module kcmu_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [kcmu_pkg::CC_W-1:0]        i_cfg_wr_data,
    input  logic                             i_accept,
    input  kcmu_pkg::t_in_item               i_item,
    output logic                             o_rec_push,
    output kcmu_pkg::t_rec                   o_rec
);

    logic [kcmu_pkg::CC_W-1:0]         r_cluster_count;
    logic [kcmu_pkg::LANE_W-1:0]       r_lane;
    logic [kcmu_pkg::IDX_W-1:0]        r_cluster;
    logic signed [kcmu_pkg::ACC_W-1:0] r_acc_x;
    logic signed [kcmu_pkg::ACC_W-1:0] r_acc_y;
    logic [kcmu_pkg::PT_W-1:0]         r_pts;

    logic signed [kcmu_pkg::ACC_W-1:0] n_acc_x;
    logic signed [kcmu_pkg::ACC_W-1:0] n_acc_y;
    logic [kcmu_pkg::PT_W-1:0]         n_pts;
    logic [kcmu_pkg::CC_W-1:0]         w_eff;
    logic                              w_first;
    logic                              w_last_lane;
    logic                              w_last_cluster;

    assign w_first     = (r_lane == '0);
    assign w_last_lane = (r_lane == kcmu_pkg::LANE_W'(kcmu_pkg::LANES - 1));

    always_comb begin
        if (w_first) begin
            n_acc_x = kcmu_pkg::ACC_W'(i_item.old_x);
            n_acc_y = kcmu_pkg::ACC_W'(i_item.old_y);
            n_pts   = '0;
        end else begin
            n_acc_x = r_acc_x;
            n_acc_y = r_acc_y;
            n_pts   = r_pts;
        end
        n_acc_x = n_acc_x + kcmu_pkg::ACC_W'(i_item.lane_sum_x);
        n_acc_y = n_acc_y + kcmu_pkg::ACC_W'(i_item.lane_sum_y);
        n_pts   = n_pts + kcmu_pkg::PT_W'(i_item.lane_points);
    end

    always_comb begin
        priority if (r_cluster_count == '0) begin
            w_eff = kcmu_pkg::CC_W'(1);
        end else if (r_cluster_count > kcmu_pkg::CC_W'(kcmu_pkg::CLUSTER_LIMIT)) begin
            w_eff = kcmu_pkg::CC_W'(kcmu_pkg::CLUSTER_LIMIT);
        end else begin
            w_eff = r_cluster_count;
        end
    end

    assign w_last_cluster = ({1'b0, r_cluster} + kcmu_pkg::CC_W'(1)) >= w_eff;

    assign o_rec_push            = i_accept && w_last_lane;
    assign o_rec.cluster_index   = r_cluster;
    assign o_rec.numer_x         = n_acc_x;
    assign o_rec.numer_y         = n_acc_y;
    assign o_rec.points          = n_pts;
    assign o_rec.last_cluster    = w_last_cluster;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= kcmu_pkg::CC_W'(1);
            r_lane          <= '0;
            r_cluster       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cluster_count <= i_cfg_wr_data;
            end
            if (i_accept) begin
                if (w_last_lane) begin
                    r_lane    <= '0;
                    r_cluster <= w_last_cluster ? '0 : r_cluster + kcmu_pkg::IDX_W'(1);
                end else begin
                    r_lane    <= r_lane + kcmu_pkg::LANE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_pts   <= n_pts;
        end
    end

endmodule

@@ rtl/kcmu_fifo.sv @@
// ----------------------------------------------------------------------------
// kcmu_fifo
// short queue of merged clusters between the merge and divide sides
// ----------------------------------------------------------------------------
module kcmu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kcmu_pkg::t_rec i_data,
    input  logic           i_pop,
    output kcmu_pkg::t_rec o_data,
    output logic           o_full,
    output logic           o_empty
);

    kcmu_pkg::t_rec                    r_mem [kcmu_pkg::FIFO_DEPTH];
    logic [kcmu_pkg::FIFO_PTR_W-1:0]   r_wp;
    logic [kcmu_pkg::FIFO_PTR_W-1:0]   r_rp;
    logic [kcmu_pkg::FIFO_CNT_W-1:0]   r_cnt;
    logic                              w_wr;
    logic                              w_rd;

    assign o_full  = (r_cnt == kcmu_pkg::FIFO_CNT_W'(kcmu_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + kcmu_pkg::FIFO_PTR_W'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + kcmu_pkg::FIFO_PTR_W'(1);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + kcmu_pkg::FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - kcmu_pkg::FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/kcmu_back.sv @@
// ----------------------------------------------------------------------------
// kcmu_back
// divides merged sums by the point total less LANES-1 and holds the result transaction
// ----------------------------------------------------------------------------
module kcmu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rec_empty,
    input  kcmu_pkg::t_rec        i_rec,
    output logic                  o_rec_pop,
    input  logic                  i_out_pop,
    output logic                  o_out_valid,
    output kcmu_pkg::t_out_item   o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int QR_W = kcmu_pkg::REM_W + kcmu_pkg::ACC_W;

    logic [1:0]                         r_state;
    logic [1:0]                         n_state;
    logic [kcmu_pkg::STEP_W-1:0]        r_step;
    logic [kcmu_pkg::IDX_W-1:0]         r_idx;
    logic                               r_last;
    logic                               r_empty;
    logic                               r_neg_x;
    logic                               r_neg_y;
    logic [kcmu_pkg::PT_W-1:0]          r_div;
    logic [kcmu_pkg::ACC_W-1:0]         r_q_x;
    logic [kcmu_pkg::ACC_W-1:0]         r_q_y;
    logic [kcmu_pkg::REM_W-1:0]         r_rem_x;
    logic [kcmu_pkg::REM_W-1:0]         r_rem_y;
    logic                               r_out_valid;
    kcmu_pkg::t_out_item                r_out;

    logic signed [kcmu_pkg::TOT_W-1:0]  w_total;
    logic                               w_is_empty;
    logic [QR_W-1:0]                    w_x1;
    logic [QR_W-1:0]                    w_x2;
    logic [QR_W-1:0]                    w_y1;
    logic [QR_W-1:0]                    w_y2;
    logic                               w_out_free;

    function automatic logic [QR_W-1:0] div_step(
        input logic [kcmu_pkg::REM_W-1:0] rem,
        input logic [kcmu_pkg::ACC_W-1:0] q,
        input logic [kcmu_pkg::PT_W-1:0]  d
    );
        logic [kcmu_pkg::REM_W-1:0] t;
        logic                       b;
        t = {rem[kcmu_pkg::REM_W-2:0], q[kcmu_pkg::ACC_W-1]};
        b = (t >= {1'b0, d});
        if (b) begin
            t = t - {1'b0, d};
        end
        return {t, q[kcmu_pkg::ACC_W-2:0], b};
    endfunction

    function automatic logic [kcmu_pkg::ACC_W-1:0] magnitude(
        input logic signed [kcmu_pkg::ACC_W-1:0] v
    );
        return v[kcmu_pkg::ACC_W-1] ? kcmu_pkg::ACC_W'(-v) : kcmu_pkg::ACC_W'(v);
    endfunction

    function automatic logic [kcmu_pkg::COORD_W-1:0] saturate(
        input logic                       neg,
        input logic [kcmu_pkg::ACC_W-1:0] mag
    );
        logic [kcmu_pkg::COORD_W-1:0] res;
        if (neg) begin
            if (mag > kcmu_pkg::ACC_W'(64'h8000_0000)) begin
                res = kcmu_pkg::COORD_W'(32'h8000_0000);
            end else begin
                res = kcmu_pkg::COORD_W'(~mag + kcmu_pkg::ACC_W'(1));
            end
        end else begin
            if (mag > kcmu_pkg::ACC_W'(64'h7FFF_FFFF)) begin
                res = kcmu_pkg::COORD_W'(32'h7FFF_FFFF);
            end else begin
                res = mag[kcmu_pkg::COORD_W-1:0];
            end
        end
        return res;
    endfunction

    assign w_total    = $signed({1'b0, i_rec.points})
                      - kcmu_pkg::TOT_W'(kcmu_pkg::LANES - 1);
    assign w_is_empty = w_total[kcmu_pkg::TOT_W-1] || (w_total == '0);

    assign w_x1 = div_step(r_rem_x, r_q_x, r_div);
    assign w_x2 = div_step(w_x1[QR_W-1 -: kcmu_pkg::REM_W],
                           w_x1[kcmu_pkg::ACC_W-1:0], r_div);
    assign w_y1 = div_step(r_rem_y, r_q_y, r_div);
    assign w_y2 = div_step(w_y1[QR_W-1 -: kcmu_pkg::REM_W],
                           w_y1[kcmu_pkg::ACC_W-1:0], r_div);

    assign w_out_free  = !r_out_valid || i_out_pop;
    assign o_rec_pop   = (r_state == S_IDLE) && !i_rec_empty;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_rec_empty) begin
                    n_state = w_is_empty ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == kcmu_pkg::STEP_W'(kcmu_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + kcmu_pkg::STEP_W'(1);
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_idx   <= i_rec.cluster_index;
            r_last  <= i_rec.last_cluster;
            r_empty <= w_is_empty;
            r_neg_x <= i_rec.numer_x[kcmu_pkg::ACC_W-1];
            r_neg_y <= i_rec.numer_y[kcmu_pkg::ACC_W-1];
            r_div   <= w_total[kcmu_pkg::PT_W-1:0];
            r_q_x   <= magnitude(i_rec.numer_x);
            r_q_y   <= magnitude(i_rec.numer_y);
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (r_state == S_DIV) begin
            r_rem_x <= w_x2[QR_W-1 -: kcmu_pkg::REM_W];
            r_q_x   <= w_x2[kcmu_pkg::ACC_W-1:0];
            r_rem_y <= w_y2[QR_W-1 -: kcmu_pkg::REM_W];
            r_q_y   <= w_y2[kcmu_pkg::ACC_W-1:0];
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.cluster_index <= r_idx;
            r_out.empty_cluster <= r_empty;
            r_out.last_cluster  <= r_last;
            r_out.new_x         <= r_empty ? '0 : saturate(r_neg_x, r_q_x);
            r_out.new_y         <= r_empty ? '0 : saturate(r_neg_y, r_q_y);
        end
    end

endmodule

@@ rtl/kmeans_centroid_merge_update.sv @@
// a cluster's totals are queued at the edge that accepts its last lane record; the divider
//   then loads them, divides at 2 quotient bits per step and writes the output register
//   once it is free; an empty cluster skips the divide
// throughput: one lane record per cycle while the queue has room; the divider takes a new
//   cluster only once it has finished and written out the previous one
// reset: synchronous active low; clears counters and the queue, cluster_count returns to 1
// ----------------------------------------------------------------------------
// kmeans_centroid_merge_update
// merges per-lane k-means partial sums and computes the new 2-d centroids
// ----------------------------------------------------------------------------
`include "kmeans_centroid_merge_update_defines.svh"

module kmeans_centroid_merge_update (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [kcmu_pkg::CC_W-1:0]    i_cfg_wr_data,
    input  logic                         push,
    output logic                         full,
    input  kcmu_pkg::t_in_item           i_in_item,
    output logic                         empty,
    input  logic                         pop,
    output kcmu_pkg::t_out_item          o_out_item
);

    logic           w_accept;
    logic           w_fifo_push;
    logic           w_fifo_pop;
    logic           w_fifo_full;
    logic           w_fifo_empty;
    logic           w_out_valid;
    logic           w_out_zero;
    kcmu_pkg::t_rec w_rec_in;
    kcmu_pkg::t_rec w_rec_out;

    assign full       = w_fifo_full;
    assign w_accept   = push && !full;
    assign empty      = !w_out_valid;
    assign w_out_zero = (o_out_item.new_x == '0) && (o_out_item.new_y == '0);

    kcmu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_item        (i_in_item),
        .o_rec_push    (w_fifo_push),
        .o_rec         (w_rec_in)
    );

    kcmu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fifo_push),
        .i_data  (w_rec_in),
        .i_pop   (w_fifo_pop),
        .o_data  (w_rec_out),
        .o_full  (w_fifo_full),
        .o_empty (w_fifo_empty)
    );

    kcmu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_empty (w_fifo_empty),
        .i_rec       (w_rec_out),
        .o_rec_pop   (w_fifo_pop),
        .i_out_pop   (pop && !empty),
        .o_out_valid (w_out_valid),
        .o_out       (o_out_item)
    );

    `KCMU_ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, w_fifo_push && w_fifo_full)
    `KCMU_ASSERT_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, w_fifo_pop && w_fifo_empty)
    `KCMU_ASSERT(a_empty_zero, i_clk, i_rst_n, !empty && o_out_item.empty_cluster |-> w_out_zero)

endmodule
